### hw/rtl/sap_pkg.sv
// ----------------------------------------------------------------------------
// sap_pkg: shared definitions for the stereo all-pass phaser
// Sizes, Q-format helpers, register indexes and the section control word.
// ----------------------------------------------------------------------------
package sap_pkg;

  // Sizes
  localparam int MAX_SECTION_PAIRS = 12;
  localparam int SAMPLE_BITS       = 24;
  localparam int SECTIONS          = 2 * MAX_SECTION_PAIRS;
  localparam int SEC_AW            = $clog2(SECTIONS);
  localparam int SEC_CW            = $clog2(SECTIONS + 1);
  localparam int MEM_W             = 32;
  localparam int COEF_W            = 16;
  localparam int PAIRS_W           = 4;

  // Configuration port
  localparam int CFG_W  = 16;
  localparam int CFG_AW = 3;

  typedef logic [CFG_AW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PAN_BALANCE   = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_FEEDBACK_GAIN = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_CROSS_MIX     = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_SECTION_PAIRS = cfg_idx_t'(3);
  localparam cfg_idx_t CFG_INVERT_OUTPUT = cfg_idx_t'(4);

  // Stream widths, whole bytes
  localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + 2 * COEF_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  // Working widths for rounding and saturation
  localparam int PROD_W   = 64;
  localparam int SAT_IN_W = 48;

  localparam logic signed [PROD_W-1:0] HALF_Q16 = PROD_W'(32768);
  localparam logic signed [PROD_W-1:0] HALF_Q15 = PROD_W'(16384);

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  // Per-step control for both channel section engines
  typedef struct packed {
    logic              rd_en;
    logic [SEC_AW-1:0] rd_addr;
    logic              wr_en;
    logic [SEC_AW-1:0] wr_addr;
    logic              ld_x;
    logic              ld_m;
    logic              mul_nm;
    logic              sub_x;
  } sap_ctrl_t;

  // Round half up then floor shift, Q0.16 products
  function automatic logic signed [SAT_IN_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    q = p + HALF_Q16;
    return SAT_IN_W'(q >>> 16);
  endfunction

  // Round half up then floor shift, Q1.15 products
  function automatic logic signed [SAT_IN_W-1:0] rnd_q15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    q = p + HALF_Q15;
    return SAT_IN_W'(q >>> 15);
  endfunction

  // Saturate to the sample range
  function automatic smp_t sat_smp(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-SAMPLE_BITS:0] hi;
    hi = v[SAT_IN_W-1:SAMPLE_BITS-1];
    if (!v[SAT_IN_W-1] && (|hi)) begin
      sat_smp = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (v[SAT_IN_W-1] && !(&hi)) begin
      sat_smp = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_smp = v[SAMPLE_BITS-1:0];
    end
  endfunction

  // Saturate to the section memory word
  function automatic logic signed [MEM_W-1:0] sat_mem(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-MEM_W:0] hi;
    hi = v[SAT_IN_W-1:MEM_W-1];
    if (!v[SAT_IN_W-1] && (|hi)) begin
      sat_mem = {1'b0, {(MEM_W-1){1'b1}}};
    end else if (v[SAT_IN_W-1] && !(&hi)) begin
      sat_mem = {1'b1, {(MEM_W-1){1'b0}}};
    end else begin
      sat_mem = v[MEM_W-1:0];
    end
  endfunction

endpackage

### hw/rtl/stereo_allpass_phaser.sv
// ----------------------------------------------------------------------------
// stereo_allpass_phaser: stereo phaser core
// Pan and feedback, two all-pass cascades held in section memories,
// cross-mix, feedback scaling and optional output inversion.
// Sequence: pan, then N = 2 * min(section_pairs, 12) sections per channel,
//   cross-mix and feedback. A new item is taken only when idle, once the
//   last result is stored; each section takes three dependent steps
//   through the one multiplier of its channel engine.
// Reset: registers take their reset values, feedback clears and the section
//   memories read as zero through per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module stereo_allpass_phaser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // in_left, in_right, coef_left, coef_right (lowest bits first)
  input  logic [sap_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_left, out_right (lowest bits first)
  output logic [sap_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Configuration writes
  input  logic                              cfg_we_i,
  input  sap_pkg::cfg_idx_t                 cfg_idx_i,
  input  logic [sap_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int SB  = sap_pkg::SAMPLE_BITS;
  localparam int CW  = sap_pkg::COEF_W;
  localparam int MPW = SB + CW + 2;     // sample by Q0.16 scale product
  localparam int FPW = SB + CW;         // sample by Q1.15 gain product

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAN_MUL,
    ST_PAN_ADD,
    ST_CAS_ADD,
    ST_CAS_MUL,
    ST_CAS_SUB,
    ST_MIX_MUL,
    ST_MIX_ADD,
    ST_FB_MUL,
    ST_FB_ADD
  } state_e;

  // Configuration registers
  logic [CW-1:0]                      pan_q;
  logic signed [CW-1:0]               fbg_q;
  logic [CW-1:0]                      cmix_q;
  logic [sap_pkg::PAIRS_W-1:0]        pairs_q;
  logic                               inv_q;
  logic                               clr;

  // Sequencer
  state_e                             state_q;
  logic [sap_pkg::SEC_AW-1:0]         j_q;
  logic [sap_pkg::SEC_CW-1:0]         j_nxt;
  logic [sap_pkg::SEC_CW-1:0]         sec_cnt;
  sap_pkg::sap_ctrl_t                 ctrl;
  logic                               in_xfer;

  // Datapath
  sap_pkg::smp_t                      xl_q, xr_q;
  logic [CW-1:0]                      gl_q, gr_q;
  logic [CW:0]                        pan_r;
  logic [CW:0]                        cmix_r;
  logic signed [MPW-1:0]              pl_q, pr_q;
  logic signed [MPW-1:0]              mla_q, mlb_q, mra_q, mrb_q;
  logic signed [FPW-1:0]              fl_q, fr_q;
  sap_pkg::smp_t                      xpl, xpr;
  sap_pkg::smp_t                      yl, yr;
  sap_pkg::smp_t                      l_q, r_q;
  sap_pkg::smp_t                      fbl_q, fbr_q;
  sap_pkg::smp_t                      fbl_d, fbr_d;
  sap_pkg::smp_t                      ol_d, or_d;
  sap_pkg::smp_t                      out_l_q, out_r_q;
  logic                               out_vld_q;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign clr = cfg_we_i && (cfg_idx_i == sap_pkg::CFG_SECTION_PAIRS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q   <= CW'(32768);
      fbg_q   <= '0;
      cmix_q  <= '0;
      pairs_q <= sap_pkg::PAIRS_W'(1);
      inv_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sap_pkg::CFG_PAN_BALANCE:   pan_q   <= cfg_data_i[CW-1:0];
        sap_pkg::CFG_FEEDBACK_GAIN: fbg_q   <= $signed(cfg_data_i[CW-1:0]);
        sap_pkg::CFG_CROSS_MIX:     cmix_q  <= cfg_data_i[CW-1:0];
        sap_pkg::CFG_SECTION_PAIRS: pairs_q <= cfg_data_i[sap_pkg::PAIRS_W-1:0];
        sap_pkg::CFG_INVERT_OUTPUT: inv_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sections per channel, clamped to the memory depth
  assign sec_cnt = (int'(pairs_q) > sap_pkg::MAX_SECTION_PAIRS) ?
                   sap_pkg::SEC_CW'(sap_pkg::SECTIONS) :
                   sap_pkg::SEC_CW'(2 * int'(pairs_q));

  assign j_nxt   = sap_pkg::SEC_CW'(j_q) + sap_pkg::SEC_CW'(1);
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Section engine control
  // ---------------------------------------------------------------------------
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_PAN_MUL: begin
        ctrl.rd_en   = (sec_cnt != '0);
        ctrl.rd_addr = '0;
      end
      ST_PAN_ADD: begin
        ctrl.ld_x = 1'b1;
        ctrl.ld_m = (sec_cnt != '0);
      end
      ST_CAS_ADD: begin
        ctrl.wr_en   = 1'b1;
        ctrl.wr_addr = j_q;
      end
      ST_CAS_MUL: begin
        ctrl.mul_nm  = 1'b1;
        ctrl.rd_en   = (j_nxt < sec_cnt);
        ctrl.rd_addr = j_nxt[sap_pkg::SEC_AW-1:0];
      end
      ST_CAS_SUB: begin
        ctrl.sub_x = 1'b1;
        ctrl.ld_m  = 1'b1;
      end
      default: ;
    endcase
  end

  sap_channel u_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (clr),
    .ctrl_i (ctrl),
    .coef_i (gl_q),
    .x_i    (xpl),
    .x_o    (yl)
  );

  sap_channel u_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (clr),
    .ctrl_i (ctrl),
    .coef_i (gr_q),
    .x_i    (xpr),
    .x_o    (yr)
  );

  // ---------------------------------------------------------------------------
  // Pan, cross-mix and feedback arithmetic
  // ---------------------------------------------------------------------------
  assign pan_r  = {1'b1, {CW{1'b0}}} - {1'b0, pan_q};
  assign cmix_r = {1'b1, {CW{1'b0}}} - {1'b0, cmix_q};

  assign xpl = sap_pkg::sat_smp(sap_pkg::rnd_q16(sap_pkg::PROD_W'(pl_q))
                                + sap_pkg::SAT_IN_W'(fbl_q));
  assign xpr = sap_pkg::sat_smp(sap_pkg::rnd_q16(sap_pkg::PROD_W'(pr_q))
                                + sap_pkg::SAT_IN_W'(fbr_q));

  assign fbl_d = sap_pkg::sat_smp(sap_pkg::rnd_q15(sap_pkg::PROD_W'(fl_q)));
  assign fbr_d = sap_pkg::sat_smp(sap_pkg::rnd_q15(sap_pkg::PROD_W'(fr_q)));

  assign ol_d = inv_q ? sap_pkg::sat_smp(-sap_pkg::SAT_IN_W'(l_q)) : l_q;
  assign or_d = inv_q ? sap_pkg::sat_smp(-sap_pkg::SAT_IN_W'(r_q)) : r_q;

  // Product and mix registers, one multiply per path
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      xl_q <= s_axis_tdata[SB-1:0];
      xr_q <= s_axis_tdata[2*SB-1:SB];
      gl_q <= s_axis_tdata[2*SB+CW-1:2*SB];
      gr_q <= s_axis_tdata[2*SB+2*CW-1:2*SB+CW];
    end
    if (state_q == ST_PAN_MUL) begin
      pl_q <= xl_q * $signed({2'b00, pan_q});
      pr_q <= xr_q * $signed({1'b0, pan_r});
    end
    if (state_q == ST_MIX_MUL) begin
      mla_q <= yl * $signed({1'b0, cmix_r});
      mlb_q <= yr * $signed({2'b00, cmix_q});
      mra_q <= yr * $signed({1'b0, cmix_r});
      mrb_q <= yl * $signed({2'b00, cmix_q});
    end
    if (state_q == ST_MIX_ADD) begin
      l_q <= sap_pkg::sat_smp(sap_pkg::rnd_q16(sap_pkg::PROD_W'(mla_q)
                                               + sap_pkg::PROD_W'(mlb_q)));
      r_q <= sap_pkg::sat_smp(sap_pkg::rnd_q16(sap_pkg::PROD_W'(mra_q)
                                               + sap_pkg::PROD_W'(mrb_q)));
    end
    if (state_q == ST_FB_MUL) begin
      fl_q <= l_q * fbg_q;
      fr_q <= r_q * fbg_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, feedback store and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      j_q       <= '0;
      fbl_q     <= '0;
      fbr_q     <= '0;
      out_l_q   <= '0;
      out_r_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            j_q     <= '0;
            state_q <= ST_PAN_MUL;
          end
        end
        ST_PAN_MUL: state_q <= ST_PAN_ADD;
        ST_PAN_ADD: state_q <= (sec_cnt == '0) ? ST_MIX_MUL : ST_CAS_ADD;
        ST_CAS_ADD: state_q <= ST_CAS_MUL;
        ST_CAS_MUL: state_q <= ST_CAS_SUB;
        ST_CAS_SUB: begin
          j_q     <= j_nxt[sap_pkg::SEC_AW-1:0];
          state_q <= (j_nxt == sec_cnt) ? ST_MIX_MUL : ST_CAS_ADD;
        end
        ST_MIX_MUL: state_q <= ST_MIX_ADD;
        ST_MIX_ADD: state_q <= ST_FB_MUL;
        ST_FB_MUL:  state_q <= ST_FB_ADD;
        ST_FB_ADD: begin
          // hold here until the result register is free
          if (!out_vld_q || m_axis_tready) begin
            fbl_q     <= fbl_d;
            fbr_q     <= fbr_d;
            out_l_q   <= ol_d;
            out_r_q   <= or_d;
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // section count write clears the feedback
      if (clr) begin
        fbl_q <= '0;
        fbr_q <= '0;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = sap_pkg::OUT_TDATA_W'({out_r_q, out_l_q});

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.wr_en |-> (sap_pkg::SEC_CW'(ctrl.wr_addr) < sec_cnt))
    else $error("section write beyond the active cascade");

  a_zero_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAN_ADD) && (sec_cnt == '0) |=> (state_q == ST_MIX_MUL))
    else $error("empty cascade not bypassed");

  a_fb_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FB_ADD) && !clr |=> $stable(fbl_q) && $stable(fbr_q))
    else $error("feedback changed outside its update step");

  a_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FB_ADD) && out_vld_q && !m_axis_tready |=> (state_q == ST_FB_ADD))
    else $error("result overran a pending transfer");

endmodule

### hw/rtl/sap_channel.sv
// ----------------------------------------------------------------------------
// sap_channel: all-pass section engine for one channel
// Section memory with registered read, one shared multiplier and the
// add / multiply / subtract steps of each first-order all-pass section.
// ----------------------------------------------------------------------------
module sap_channel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  sap_pkg::sap_ctrl_t        ctrl_i,
  input  logic [sap_pkg::COEF_W-1:0] coef_i,
  input  sap_pkg::smp_t             x_i,
  output sap_pkg::smp_t             x_o
);

  // Section memory and per-entry valid bits
  logic [sap_pkg::MEM_W-1:0]    mem_q [sap_pkg::SECTIONS];
  logic [sap_pkg::SECTIONS-1:0] valid_q;
  logic [sap_pkg::MEM_W-1:0]    rd_data_q;
  logic                         rd_vld_q;

  // Datapath
  logic signed [sap_pkg::MEM_W-1:0]          rd_word;
  logic signed [sap_pkg::MEM_W-1:0]          tmp_q;
  logic signed [sap_pkg::MEM_W-1:0]          nm_q;
  logic signed [sap_pkg::MEM_W-1:0]          nm_d;
  logic signed [sap_pkg::MEM_W-1:0]          mul_a;
  logic signed [sap_pkg::MEM_W+sap_pkg::COEF_W:0] p_q;
  logic signed [sap_pkg::MEM_W+sap_pkg::COEF_W:0] p_d;
  sap_pkg::smp_t                             x_q;
  sap_pkg::smp_t                             x_sub;

  // Entries never written since the last clear read as zero
  assign rd_word = rd_vld_q ? $signed(rd_data_q) : '0;

  // One multiplier: stored sample on a load, new memory value otherwise
  assign mul_a = ctrl_i.mul_nm ? nm_q : rd_word;
  assign p_d   = mul_a * $signed({1'b0, coef_i});

  // m' = g*m + x and y = m - g*m'
  assign nm_d  = sap_pkg::sat_mem(sap_pkg::rnd_q16(sap_pkg::PROD_W'(p_q))
                                  + sap_pkg::SAT_IN_W'(x_q));
  assign x_sub = sap_pkg::sat_smp(sap_pkg::SAT_IN_W'(tmp_q)
                                  - sap_pkg::rnd_q16(sap_pkg::PROD_W'(p_q)));

  // Memory array, write and registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_addr] <= nm_d;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[ctrl_i.rd_addr];
    end
  end

  // Valid bits, cleared by reset and by a section count write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else if (clr_i) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[ctrl_i.wr_addr] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_vld_q <= valid_q[ctrl_i.rd_addr];
      end
    end
  end

  // Section step registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_m || ctrl_i.mul_nm) begin
      p_q <= p_d;
    end
    if (ctrl_i.ld_m) begin
      tmp_q <= rd_word;
    end
    if (ctrl_i.wr_en) begin
      nm_q <= nm_d;
    end
    if (ctrl_i.ld_x) begin
      x_q <= x_i;
    end else if (ctrl_i.sub_x) begin
      x_q <= x_sub;
    end
  end

  assign x_o = x_q;

endmodule

### test/tb_stereo_allpass_phaser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_allpass_phaser: self-checking bench for the stereo phaser core
// Directed extremes, then constrained-random stereo items under three
// handshake idling profiles. Register settings change between idle
// stretches. Each transfer is predicted by a bit-exact model of the pan,
// feedback, all-pass cascade and cross-mix path, and results are checked in
// order.
// ----------------------------------------------------------------------------
module tb_stereo_allpass_phaser;

  localparam int     WATCHDOG_LIMIT = 20000;
  localparam int     END_SETTLE     = 100;
  localparam int     ITEMS_PER_SEG  = 172;
  localparam longint SMP_HI_L       = (longint'(1) <<< (sap_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SMP_LO_L       = -SMP_HI_L - 1;
  localparam longint WORD_HI_L      = (longint'(1) <<< (sap_pkg::MEM_W - 1)) - 1;
  localparam longint WORD_LO_L      = -WORD_HI_L - 1;
  localparam sap_pkg::smp_t SMP_HI  = {1'b0, {(sap_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam sap_pkg::smp_t SMP_LO  = {1'b1, {(sap_pkg::SAMPLE_BITS-1){1'b0}}};

  typedef struct {
    sap_pkg::smp_t in_l;
    sap_pkg::smp_t in_r;
    logic [15:0]   g_l;
    logic [15:0]   g_r;
  } stereo_in_t;

  typedef struct {
    sap_pkg::smp_t out_l;
    sap_pkg::smp_t out_r;
  } stereo_out_t;

  // DUT connections
  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // in_left, in_right, coef_left, coef_right (lowest bits first)
  logic [sap_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // out_left, out_right (lowest bits first)
  logic [sap_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_we_i      = 1'b0;
  sap_pkg::cfg_idx_t               cfg_idx_i     = sap_pkg::CFG_PAN_BALANCE;
  logic [sap_pkg::CFG_W-1:0]       cfg_data_i    = '0;

  // Bench state
  stereo_in_t  pending_q[$];
  stereo_out_t expected_q[$];
  stereo_in_t  cur_item;
  bit          in_flight    = 1'b0;
  int          tx_idle_pct  = 0;
  int          rx_idle_pct  = 0;
  int          n_fail       = 0;
  int          stall_cycles = 0;

  // Predictor copy of registers and storage
  longint cfg_pan, cfg_fbg, cfg_mix, cfg_pairs, cfg_inv;
  longint sect_mem [2][sap_pkg::SECTIONS];
  longint fb_val   [2];

  stereo_allpass_phaser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 125 MHz clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  // Round half up, floor shift
  function automatic longint round_shift(input longint p, input int s);
    return (p + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip_sample(input longint v);
    if (v > SMP_HI_L) return SMP_HI_L;
    if (v < SMP_LO_L) return SMP_LO_L;
    return v;
  endfunction

  function automatic longint clip_word(input longint v);
    if (v > WORD_HI_L) return WORD_HI_L;
    if (v < WORD_LO_L) return WORD_LO_L;
    return v;
  endfunction

  function automatic void clear_storage();
    for (int ch = 0; ch < 2; ch++) begin
      for (int j = 0; j < sap_pkg::SECTIONS; j++) sect_mem[ch][j] = 0;
      fb_val[ch] = 0;
    end
  endfunction

  // One channel through n first-order all-pass sections
  function automatic longint allpass_chain(input longint x, input longint g,
                                           input int ch, input int n);
    longint prev, nm;
    for (int j = 0; j < n; j++) begin
      prev = sect_mem[ch][j];
      nm = clip_word(round_shift(prev * g, 16) + x);
      sect_mem[ch][j] = nm;
      x = clip_sample(prev - round_shift(nm * g, 16));
    end
    return x;
  endfunction

  function automatic stereo_out_t phaser_predict(input stereo_in_t it);
    longint xl, xr, mix_c, mix_cc, l, r;
    int n;
    stereo_out_t res;
    n = (cfg_pairs > sap_pkg::MAX_SECTION_PAIRS) ? 2 * sap_pkg::MAX_SECTION_PAIRS
                                                 : 2 * int'(cfg_pairs);
    mix_c  = cfg_mix;
    mix_cc = 65536 - cfg_mix;
    xl = clip_sample(round_shift(longint'(it.in_l) * cfg_pan, 16) + fb_val[0]);
    xr = clip_sample(round_shift(longint'(it.in_r) * (65536 - cfg_pan), 16) + fb_val[1]);
    xl = allpass_chain(xl, longint'(it.g_l), 0, n);
    xr = allpass_chain(xr, longint'(it.g_r), 1, n);
    l = clip_sample(round_shift(xl * mix_cc + xr * mix_c, 16));
    r = clip_sample(round_shift(xr * mix_cc + xl * mix_c, 16));
    fb_val[0] = clip_sample(round_shift(l * cfg_fbg, 15));
    fb_val[1] = clip_sample(round_shift(r * cfg_fbg, 15));
    if (cfg_inv != 0) begin
      l = clip_sample(-l);
      r = clip_sample(-r);
    end
    res.out_l = sap_pkg::smp_t'(l);
    res.out_r = sap_pkg::smp_t'(r);
    return res;
  endfunction

  // ---------------------------------------------------------------- driver
  // Presents queued items; predicts each one on its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      in_flight = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(phaser_predict(cur_item));
        in_flight = 1'b0;
      end
      if (!in_flight && pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        cur_item  = pending_q.pop_front();
        in_flight = 1'b1;
      end
      s_axis_tvalid <= in_flight;
      s_axis_tdata  <= {cur_item.g_r, cur_item.g_l, cur_item.in_r, cur_item.in_l};
    end
  end

  // ---------------------------------------------------------------- monitor
  // Checks each result transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    stereo_out_t   want;
    sap_pkg::smp_t got_l, got_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_l = m_axis_tdata[sap_pkg::SAMPLE_BITS-1:0];
        got_r = m_axis_tdata[2*sap_pkg::SAMPLE_BITS-1:sap_pkg::SAMPLE_BITS];
        if (expected_q.size() == 0) begin
          $error("unexpected result: out_left %0d out_right %0d", got_l, got_r);
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          if (got_l !== want.out_l) begin
            $error("out_left: expected %0d, actual %0d", want.out_l, got_l);
            n_fail++;
          end
          if (got_r !== want.out_r) begin
            $error("out_right: expected %0d, actual %0d", want.out_r, got_r);
            n_fail++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: cycles with no transfer on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic cfg_write(input sap_pkg::cfg_idx_t idx,
                           input logic [sap_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      sap_pkg::CFG_PAN_BALANCE:   cfg_pan   = longint'(val);
      sap_pkg::CFG_FEEDBACK_GAIN: cfg_fbg   = longint'(signed'(val));
      sap_pkg::CFG_CROSS_MIX:     cfg_mix   = longint'(val);
      sap_pkg::CFG_SECTION_PAIRS: begin
        cfg_pairs = longint'(val[sap_pkg::PAIRS_W-1:0]);
        clear_storage();
      end
      sap_pkg::CFG_INVERT_OUTPUT: cfg_inv   = longint'(val[0]);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until the sender is empty and every prediction has been matched
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_flight || expected_q.size() != 0);
  endtask

  function automatic void queue_item(input sap_pkg::smp_t l, input sap_pkg::smp_t r,
                                     input logic [15:0] gl, input logic [15:0] gr);
    stereo_in_t it;
    it.in_l = l;
    it.in_r = r;
    it.g_l  = gl;
    it.g_r  = gr;
    pending_q.push_back(it);
  endfunction

  function automatic sap_pkg::smp_t rand_sample();
    case ($urandom_range(9))
      0:       return SMP_HI;
      1:       return SMP_LO;
      2:       return sap_pkg::smp_t'(int'($urandom_range(2000)) - 1000);
      default: return sap_pkg::smp_t'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_word(input logic [15:0] lo, input logic [15:0] hi);
    case ($urandom_range(3))
      0:       return lo;
      1:       return hi;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int n);
    @(negedge clk_i);
    for (int i = 0; i < n; i++) begin
      queue_item(rand_sample(), rand_sample(),
                 pick_word(16'h0000, 16'hFFFF), pick_word(16'h0000, 16'hFFFF));
    end
  endtask

  // New register setting; the section count is sometimes left alone so that
  // the section memories carry over
  task automatic random_config();
    int pairs_v;
    case ($urandom_range(9))
      0:       pairs_v = 0;
      1:       pairs_v = sap_pkg::MAX_SECTION_PAIRS;
      2:       pairs_v = $urandom_range(15, sap_pkg::MAX_SECTION_PAIRS + 1);
      default: pairs_v = $urandom_range(3, 1);
    endcase
    cfg_write(sap_pkg::CFG_PAN_BALANCE,   pick_word(16'h0000, 16'hFFFF));
    cfg_write(sap_pkg::CFG_FEEDBACK_GAIN, pick_word(16'h8000, 16'h7FFF));
    cfg_write(sap_pkg::CFG_CROSS_MIX,     pick_word(16'h0000, 16'hFFFF));
    cfg_write(sap_pkg::CFG_INVERT_OUTPUT, {15'($urandom), 1'($urandom)});
    if ($urandom_range(3) != 0) begin
      cfg_write(sap_pkg::CFG_SECTION_PAIRS, {12'($urandom), 4'(pairs_v)});
    end
    if ($urandom_range(2) == 0) begin
      cfg_write(sap_pkg::cfg_idx_t'(sap_pkg::CFG_INVERT_OUTPUT + 1 + $urandom_range(2)),
                16'($urandom));
    end
  endtask

  initial begin
    cfg_pan   = 32768;
    cfg_fbg   = 0;
    cfg_mix   = 0;
    cfg_pairs = 1;
    cfg_inv   = 0;
    clear_storage();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, field extremes
    @(negedge clk_i);
    queue_item(sap_pkg::smp_t'(0), sap_pkg::smp_t'(0), 16'h0000, 16'h0000);
    queue_item(SMP_HI, SMP_HI, 16'h0000, 16'hFFFF);
    queue_item(SMP_LO, SMP_LO, 16'hFFFF, 16'h0000);
    queue_item(SMP_HI, SMP_LO, 16'hFFFF, 16'hFFFF);
    queue_item(SMP_LO, SMP_HI, 16'h8000, 16'h7FFF);
    queue_item(sap_pkg::smp_t'(1), sap_pkg::smp_t'(-1), 16'h0001, 16'hFFFE);
    queue_item(SMP_HI, SMP_HI, 16'hFFFF, 16'hFFFF);
    queue_item(SMP_LO, SMP_LO, 16'hFFFF, 16'hFFFF);
    wait_drained();

    // Zero sections, full positive feedback into saturation, inverted:
    // negating the minimum must give the maximum
    cfg_write(sap_pkg::CFG_PAN_BALANCE,   16'hFFFF);
    cfg_write(sap_pkg::CFG_FEEDBACK_GAIN, 16'h7FFF);
    cfg_write(sap_pkg::CFG_CROSS_MIX,     16'h0000);
    cfg_write(sap_pkg::CFG_SECTION_PAIRS, 16'h0000);
    cfg_write(sap_pkg::CFG_INVERT_OUTPUT, 16'h0001);
    @(negedge clk_i);
    for (int i = 0; i < 5; i++) queue_item(SMP_LO, SMP_LO, 16'hFFFF, 16'h0000);
    queue_item(SMP_HI, SMP_HI, 16'h0000, 16'hFFFF);
    wait_drained();

    // Section count above the maximum, full cross-mix, negative feedback;
    // writes to indexes past the register list must be ignored
    cfg_write(sap_pkg::CFG_PAN_BALANCE,   16'h0000);
    cfg_write(sap_pkg::CFG_FEEDBACK_GAIN, 16'h8000);
    cfg_write(sap_pkg::CFG_CROSS_MIX,     16'hFFFF);
    cfg_write(sap_pkg::CFG_SECTION_PAIRS, 16'h000F);
    cfg_write(sap_pkg::CFG_INVERT_OUTPUT, 16'h0000);
    for (int k = 1; k <= 3; k++) begin
      cfg_write(sap_pkg::cfg_idx_t'(sap_pkg::CFG_INVERT_OUTPUT + k), 16'hFFFF);
    end
    @(negedge clk_i);
    queue_item(SMP_HI, SMP_LO, 16'hFFFF, 16'h0000);
    queue_item(SMP_LO, SMP_HI, 16'h0000, 16'hFFFF);
    queue_item(SMP_HI, SMP_HI, 16'hC000, 16'h4000);
    queue_item(SMP_LO, SMP_LO, 16'hFFFF, 16'hFFFF);
    queue_item(sap_pkg::smp_t'(0), SMP_HI, 16'h8000, 16'h8000);
    queue_item(SMP_HI, sap_pkg::smp_t'(0), 16'hFFFF, 16'h0001);
    wait_drained();

    // Random part: three idling profiles, several settings each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin tx_idle_pct = 35; rx_idle_pct = 60; end
        1:       begin tx_idle_pct = 60; rx_idle_pct = 35; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      for (int sg = 0; sg < 3; sg++) begin
        wait_drained();
        random_config();
        // hold the sender mid-way until the pipeline is empty
        queue_random(ITEMS_PER_SEG / 2);
        wait_drained();
        queue_random(ITEMS_PER_SEG - ITEMS_PER_SEG / 2);
      end
    end

    wait_drained();
    repeat (END_SETTLE) @(posedge clk_i);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sap_pkg.sv
hw/rtl/sap_channel.sv
hw/rtl/stereo_allpass_phaser.sv
test/tb_stereo_allpass_phaser.sv
